@@ src/lree_pkg.sv @@
// Shared types, parse tables and arithmetic helpers for the LR expression evaluator.
`timescale 1ns / 1ps
`default_nettype none
package lree_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned MAX_RESULTS     = 64;
  localparam int unsigned QCW             = $clog2(MAX_RESULTS);
  localparam int unsigned DIV_STEPS       = 48;
  localparam int unsigned DCW             = $clog2(DIV_STEPS);
  localparam logic [3:0]  KIND_VALUE      = 4'd8;
  localparam logic signed [31:0] Q_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN    = 32'sh8000_0000;

  typedef enum logic [2:0] {
    TOK_END, TOK_PLUS, TOK_MINUS, TOK_TIMES, TOK_DIV, TOK_NUM, TOK_OPEN, TOK_CLOSE
  } tok_e;

  typedef enum logic [1:0] { RES_QUAD, RES_FINAL, RES_ERROR } res_e;

  typedef enum logic [2:0] { OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG } op_e;

  typedef enum logic [2:0] {
    ERR_LEX, ERR_MISSING, ERR_PAREN, ERR_BADOP, ERR_OTHER
  } err_e;

  typedef enum logic [1:0] { ACT_ERR, ACT_SHIFT, ACT_ACC, ACT_RED } act_e;

  typedef enum logic [2:0] {
    RC_UNIT, RC_ADD, RC_SUB, RC_MUL, RC_DIV, RC_NEG, RC_PAREN
  } rcls_e;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_ACT, S_ERRK, S_FAIL, S_RED, S_MUL, S_DIVGO, S_DIVW, S_WB, S_FLUSH
  } ctrl_state_e;

  typedef enum logic [3:0] {
    C_NONE, C_LOAD, C_DISC, C_SHIFT, C_ACC, C_FAIL, C_CALC, C_MULFIN,
    C_DIVGO, C_DIVFIN, C_WB, C_FLUSH
  } cmd_e;

  typedef struct packed {
    logic [2:0]        token_kind;
    logic              lexical_bad;
    logic signed [31:0] number_value;
  } token_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [2:0]         operation;
    logic signed [31:0] left_operand;
    logic signed [31:0] right_operand;
    logic signed [31:0] value_out;
    logic [2:0]         error_code;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    act_e       typ;
    logic [4:0] arg;
  } act_t;

  typedef struct packed {
    cmd_e       op;
    logic [2:0] code;
  } cmd_t;

  typedef struct packed {
    logic       disc;
    logic       tok_bad;
    logic       tok_end;
    logic       top_zero;
    act_e       act;
    logic       full;
    logic       short_stk;
    logic       goto_bad;
    rcls_e      rcls;
    logic       wb_emit;
    logic       emit_ok;
    logic       pend_v;
    logic       out_free;
    logic       div_done;
    logic [2:0] end_code;
    logic [2:0] tok_code;
  } stat_t;

  // SLR action table: shift target or rule number
  function automatic act_t act_f(input logic [4:0] st, input logic [2:0] kd);
    act_t a;
    a = '{ACT_ERR, 5'd0};
    case (st)
      5'd0, 5'd5, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11: begin
        case (kd)
          TOK_MINUS: a = '{ACT_SHIFT, 5'd5};
          TOK_NUM:   a = '{ACT_SHIFT, 5'd6};
          TOK_OPEN:  a = '{ACT_SHIFT, 5'd7};
          default:   a = '{ACT_ERR, 5'd0};
        endcase
      end
      5'd1: begin
        case (kd)
          TOK_END:   a = '{ACT_ACC, 5'd0};
          TOK_PLUS:  a = '{ACT_SHIFT, 5'd8};
          TOK_MINUS: a = '{ACT_SHIFT, 5'd9};
          default:   a = '{ACT_ERR, 5'd0};
        endcase
      end
      5'd2, 5'd15, 5'd16: begin
        case (kd)
          TOK_TIMES: a = '{ACT_SHIFT, 5'd10};
          TOK_DIV:   a = '{ACT_SHIFT, 5'd11};
          default: begin
            if (st == 5'd2)       a = '{ACT_RED, 5'd4};
            else if (st == 5'd15) a = '{ACT_RED, 5'd2};
            else                  a = '{ACT_RED, 5'd3};
          end
        endcase
      end
      5'd3:         a = '{ACT_RED, 5'd7};
      5'd4, 5'd13:  a = '{ACT_RED, 5'd8};
      5'd6:         a = '{ACT_RED, 5'd10};
      5'd12:        a = '{ACT_RED, 5'd9};
      5'd14: begin
        case (kd)
          TOK_PLUS:  a = '{ACT_SHIFT, 5'd8};
          TOK_MINUS: a = '{ACT_SHIFT, 5'd9};
          TOK_CLOSE: a = '{ACT_SHIFT, 5'd19};
          default:   a = '{ACT_ERR, 5'd0};
        endcase
      end
      5'd17:        a = '{ACT_RED, 5'd5};
      5'd18:        a = '{ACT_RED, 5'd6};
      5'd19:        a = '{ACT_RED, 5'd11};
      default:      a = '{ACT_ERR, 5'd0};
    endcase
    return a;
  endfunction

  // goto table, bit 5 set when the entry exists
  function automatic logic [5:0] goto_f(input logic [4:0] st, input logic [1:0] lhs);
    logic [5:0] g;
    g = 6'd0;
    case (st)
      5'd0: begin
        case (lhs)
          2'd0: g = {1'b1, 5'd1};
          2'd1: g = {1'b1, 5'd2};
          2'd2: g = {1'b1, 5'd3};
          default: g = {1'b1, 5'd4};
        endcase
      end
      5'd5, 5'd10, 5'd11: begin
        case (lhs)
          2'd2: begin
            if (st == 5'd5)       g = {1'b1, 5'd12};
            else if (st == 5'd10) g = {1'b1, 5'd17};
            else                  g = {1'b1, 5'd18};
          end
          2'd3: g = {1'b1, 5'd4};
          default: g = 6'd0;
        endcase
      end
      5'd7, 5'd8, 5'd9: begin
        case (lhs)
          2'd0: g = (st == 5'd7) ? {1'b1, 5'd14} : 6'd0;
          2'd1: begin
            if (st == 5'd7)      g = {1'b1, 5'd2};
            else if (st == 5'd8) g = {1'b1, 5'd15};
            else                 g = {1'b1, 5'd16};
          end
          2'd2: g = {1'b1, 5'd3};
          default: g = {1'b1, 5'd4};
        endcase
      end
      default: g = 6'd0;
    endcase
    return g;
  endfunction

  function automatic logic [1:0] rule_len_f(input logic [3:0] r);
    case (r)
      4'd2, 4'd3, 4'd5, 4'd6, 4'd11: return 2'd3;
      4'd9:                          return 2'd2;
      default:                       return 2'd1;
    endcase
  endfunction

  function automatic logic [1:0] rule_lhs_f(input logic [3:0] r);
    case (r)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4: return 2'd0;
      4'd5, 4'd6, 4'd7:             return 2'd1;
      4'd8, 4'd9:                   return 2'd2;
      default:                      return 2'd3;
    endcase
  endfunction

  function automatic rcls_e rule_cls_f(input logic [3:0] r);
    case (r)
      4'd2:    return RC_ADD;
      4'd3:    return RC_SUB;
      4'd5:    return RC_MUL;
      4'd6:    return RC_DIV;
      4'd9:    return RC_NEG;
      4'd11:   return RC_PAREN;
      default: return RC_UNIT;
    endcase
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    if (x[32] != x[31]) return x[32] ? Q_MIN : Q_MAX;
    return x[31:0];
  endfunction

endpackage
`default_nettype wire

@@ src/lr_expression_evaluator_unit.sv @@
// Top level of the SLR(1) arithmetic expression evaluator.
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one lexical token per
//   transaction; a line is closed by an end token. Output channel (out_valid_o/
//   out_ready_i/out_data_o) carries result transactions: a quadruple for each
//   arithmetic reduction (unary minus too), up to 63 per token, the final value
//   on acceptance, or one error code, after which tokens are dropped up to the
//   next end token. last_of_run marks the final result caused by a token.
// Timing: one token at a time. A plain shift passes the load, check, action and
//   flush states; each reduction adds the calculate and write-back states, a
//   multiply a finish state, and a divide the one-bit-per-cycle divider (a zero
//   divisor finishes at once). Discarded tokens and empty lines stop after check.
// Stall: the newest result waits in a pending slot until its last flag is known,
//   then moves to the output register; the sequencer halts while that register
//   is still full, so no result is lost when the receiver holds out_ready_i low.
// Reset: stack empty (top entry is parse state 0), not discarding, both output
//   stages empty. Stack RAM contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module lr_expression_evaluator_unit import lree_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire token_t in_data_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output result_t     out_data_o
);
  cmd_t  cmd;
  stat_t stat;

  // sequencer: one token in flight, steps through shift/reduce/emit
  lree_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .stat_i(stat), .cmd_o(cmd)
  );

  // stacks in RAM with cached top entry, arithmetic, two-stage result buffer
  lree_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk_i, .rst_ni, .in_data_i, .out_ready_i, .out_valid_o, .out_data_o,
    .cmd_i(cmd), .stat_o(stat)
  );
endmodule
`default_nettype wire

@@ src/lree_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lree_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ src/lree_div.sv @@
// Iterative Q16.16 divider, one quotient bit per cycle, saturating.
`timescale 1ns / 1ps
`default_nettype none
module lree_div import lree_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output logic                    done_o,
  output logic signed [31:0]      q_o
);
  logic                 busy_q, fin_q, done_q, neg_q;
  logic [DCW-1:0]       cnt_q;
  logic [31:0]          rem_q, dvs_q;
  logic [DIV_STEPS-1:0] dvd_q;
  logic signed [31:0]   q_q;
  logic [32:0]          sh;
  logic                 fits;
  logic [31:0]          abs_a, abs_b;

  assign abs_a = a_i[31] ? (~a_i + 32'd1) : a_i;
  assign abs_b = b_i[31] ? (~b_i + 32'd1) : b_i;
  assign sh    = {rem_q, dvd_q[DIV_STEPS-1]};
  assign fits  = sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        // zero divisor finishes at once with the saturated value (zero for a zero dividend)
        done_q <= (b_i == 32'sd0);
        if (b_i != 32'sd0) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (busy_q) begin
        done_q <= 1'b0;
        cnt_q  <= cnt_q + DCW'(1);
        if (cnt_q == DCW'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= abs_b;
      dvd_q <= {abs_a, 16'd0};
      neg_q <= a_i[31] ^ b_i[31];
      if (a_i > 32'sd0)      q_q <= Q_MAX;
      else if (a_i[31])      q_q <= Q_MIN;
      else                   q_q <= 32'sd0;
    end else if (busy_q) begin
      rem_q <= fits ? 32'(sh - {1'b0, dvs_q}) : sh[31:0];
      dvd_q <= {dvd_q[DIV_STEPS-2:0], fits};
    end else if (fin_q) begin
      if (neg_q) begin
        q_q <= (dvd_q > DIV_STEPS'(33'h0_8000_0000)) ? Q_MIN : (~dvd_q[31:0] + 32'd1);
      end else begin
        q_q <= (dvd_q > DIV_STEPS'(32'h7FFF_FFFF)) ? Q_MAX : dvd_q[31:0];
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;
endmodule
`default_nettype wire

@@ src/lree_dp.sv @@
// Datapath: parse stacks, operand registers, arithmetic and result buffering.
`timescale 1ns / 1ps
`default_nettype none
module lree_dp import lree_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire token_t  in_data_i,
  input  wire logic    out_ready_i,
  output logic         out_valid_o,
  output result_t      out_data_o,
  input  wire cmd_t    cmd_i,
  output stat_t        stat_o
);
  localparam int unsigned TW = $clog2(STACK_DEPTH);

  token_t             tok_q;
  logic [TW-1:0]      top_q;
  logic [4:0]         tstate_q, g_q;
  logic signed [31:0] tval_q, a_q, b_q, v_q;
  logic [3:0]         tkind_q, vk_q;
  logic               disc_q, pend_v_q, out_v_q;
  logic [QCW-1:0]     qcnt_q;
  result_t            pend_q, out_q, new_res, push_res;
  logic signed [63:0] prod_q;

  act_t               act;
  logic [3:0]         rule;
  logic [1:0]         len;
  rcls_e              rcls;
  logic [TW-1:0]      base, dst, top_m1, top_m2, shift_addr;
  logic [4:0]         st_rd, st_base;
  logic [3:0]         kind_rd;
  logic signed [31:0] val_rd;
  logic [5:0]         go;
  logic               is_quad, wb_emit, emit, flush, push, out_free, emit_ok;
  logic               we;
  logic [TW-1:0]      waddr;
  logic [4:0]         w_st;
  logic [3:0]         w_kind;
  logic signed [31:0] w_val, shift_val;
  logic               div_done;
  logic signed [31:0] div_q;
  logic [2:0]         quad_op, end_code;
  logic signed [31:0] c_a, c_b, c_v;
  logic [3:0]         c_vk;

  function automatic logic signed [31:0] mulfin(input logic signed [63:0] p);
    logic signed [63:0] r;
    logic signed [63:0] np;
    np = -p;
    r  = p[63] ? -(np >>> 16) : (p >>> 16);
    if (r > 64'sh7FFF_FFFF) return Q_MAX;
    if (r < -64'sh8000_0000) return Q_MIN;
    return r[31:0];
  endfunction

  assign act      = act_f(tstate_q, tok_q.token_kind);
  assign rule     = act.arg[3:0];
  assign len      = rule_len_f(rule);
  assign rcls     = rule_cls_f(rule);
  assign base     = top_q - TW'(len);
  assign dst      = base + TW'(1);
  assign top_m1   = top_q - TW'(1);
  assign top_m2   = top_q - TW'(2);
  assign shift_addr = top_q + TW'(1);
  assign st_base  = (base == '0) ? 5'd0 : st_rd;
  assign go       = goto_f(st_base, rule_lhs_f(rule));
  assign is_quad  = (rcls == RC_ADD) || (rcls == RC_SUB) || (rcls == RC_MUL) ||
                    (rcls == RC_DIV) || (rcls == RC_NEG);
  assign wb_emit  = is_quad && (qcnt_q < QCW'(MAX_RESULTS - 1));

  always_comb begin
    case (rcls)
      RC_ADD:  quad_op = OP_ADD;
      RC_SUB:  quad_op = OP_SUB;
      RC_MUL:  quad_op = OP_MUL;
      RC_DIV:  quad_op = OP_DIV;
      default: quad_op = OP_NEG;
    endcase
  end

  always_comb begin
    end_code = ERR_OTHER;
    if (tkind_q < 4'd5) end_code = ERR_MISSING;
    if ((top_q >= TW'(2)) && (kind_rd == {1'b0, TOK_OPEN})) end_code = ERR_PAREN;
  end

  // operands of a reduction and the results that need no multiply or divide
  always_comb begin
    c_a  = val_rd;
    c_b  = tval_q;
    c_v  = tval_q;
    c_vk = KIND_VALUE;
    case (rcls)
      RC_ADD: c_v = sat33({val_rd[31], val_rd} + {tval_q[31], tval_q});
      RC_SUB: c_v = sat33({val_rd[31], val_rd} - {tval_q[31], tval_q});
      RC_MUL, RC_DIV: c_v = tval_q;
      RC_NEG: begin
        c_a = tval_q;
        c_b = 32'sd0;
        c_v = sat33(-{tval_q[31], tval_q});
      end
      RC_PAREN: begin
        c_v  = val_rd;
        c_vk = kind_rd;
      end
      default: c_vk = tkind_q;
    endcase
  end

  // stack RAMs, written on shift and on reduction write-back
  assign shift_val = (tok_q.token_kind == TOK_NUM) ? tok_q.number_value : 32'sd0;
  assign we     = (cmd_i.op == C_SHIFT) || (cmd_i.op == C_WB);
  assign waddr  = (cmd_i.op == C_SHIFT) ? shift_addr : dst;
  assign w_st   = (cmd_i.op == C_SHIFT) ? act.arg : g_q;
  assign w_kind = (cmd_i.op == C_SHIFT) ? {1'b0, tok_q.token_kind} : vk_q;
  assign w_val  = (cmd_i.op == C_SHIFT) ? shift_val : v_q;

  lree_ram #(.WIDTH(5), .DEPTH(STACK_DEPTH)) u_st_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(w_st), .raddr_i(base), .rdata_o(st_rd)
  );
  lree_ram #(.WIDTH(4), .DEPTH(STACK_DEPTH)) u_kind_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(w_kind), .raddr_i(top_m1),
    .rdata_o(kind_rd)
  );
  lree_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_val_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(w_val),
    .raddr_i((rcls == RC_PAREN) ? top_m1 : top_m2), .rdata_o(val_rd)
  );

  lree_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.op == C_DIVGO), .a_i(a_q), .b_i(b_q),
    .done_o(div_done), .q_o(div_q)
  );

  // result staging: pending slot holds the newest result until its last flag is known
  always_comb begin
    new_res = '0;
    case (cmd_i.op)
      C_ACC: begin
        new_res.result_kind = RES_FINAL;
        new_res.value_out   = tval_q;
      end
      C_FAIL: begin
        new_res.result_kind = RES_ERROR;
        new_res.error_code  = cmd_i.code;
      end
      default: begin
        new_res.result_kind   = RES_QUAD;
        new_res.operation     = quad_op;
        new_res.left_operand  = a_q;
        new_res.right_operand = b_q;
        new_res.value_out     = v_q;
      end
    endcase
  end

  always_comb begin
    push_res             = pend_q;
    push_res.last_of_run = flush;
  end

  assign out_free = !out_v_q || out_ready_i;
  assign emit_ok  = !pend_v_q || out_free;
  assign emit     = (cmd_i.op == C_ACC) || (cmd_i.op == C_FAIL) ||
                    ((cmd_i.op == C_WB) && wb_emit);
  assign flush    = (cmd_i.op == C_FLUSH) && pend_v_q;
  assign push     = (emit && pend_v_q) || flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      if (push)             out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
      if (emit)             pend_v_q <= 1'b1;
      else if (flush)       pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) out_q <= push_res;
    if (emit) pend_q <= new_res;
  end

  // parse control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= '0;
      tstate_q <= 5'd0;
      disc_q   <= 1'b0;
      qcnt_q   <= '0;
    end else begin
      case (cmd_i.op)
        C_LOAD:  qcnt_q <= '0;
        C_DISC:  if (tok_q.token_kind == TOK_END) disc_q <= 1'b0;
        C_SHIFT: begin
          top_q    <= shift_addr;
          tstate_q <= act.arg;
        end
        C_ACC: begin
          top_q    <= '0;
          tstate_q <= 5'd0;
        end
        C_FAIL: begin
          top_q    <= '0;
          tstate_q <= 5'd0;
          disc_q   <= (tok_q.token_kind != TOK_END);
        end
        C_WB: begin
          top_q    <= dst;
          tstate_q <= g_q;
          if (wb_emit) qcnt_q <= qcnt_q + QCW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      C_LOAD:  tok_q <= in_data_i;
      C_SHIFT: begin
        tval_q  <= shift_val;
        tkind_q <= {1'b0, tok_q.token_kind};
      end
      C_CALC: begin
        a_q    <= c_a;
        b_q    <= c_b;
        v_q    <= c_v;
        vk_q   <= c_vk;
        g_q    <= go[4:0];
        prod_q <= val_rd * tval_q;
      end
      C_MULFIN: v_q <= mulfin(prod_q);
      C_DIVFIN: v_q <= div_q;
      C_WB: begin
        tval_q  <= v_q;
        tkind_q <= vk_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.disc      = disc_q;
    stat_o.tok_bad   = tok_q.lexical_bad;
    stat_o.tok_end   = (tok_q.token_kind == TOK_END);
    stat_o.top_zero  = (top_q == '0);
    stat_o.act       = act.typ;
    stat_o.full      = (top_q == TW'(STACK_DEPTH - 1));
    stat_o.short_stk = ({1'b0, top_q} < (TW + 1)'(len));
    stat_o.goto_bad  = !go[5];
    stat_o.rcls      = rcls;
    stat_o.wb_emit   = wb_emit;
    stat_o.emit_ok   = emit_ok;
    stat_o.pend_v    = pend_v_q;
    stat_o.out_free  = out_free;
    stat_o.div_done  = div_done;
    stat_o.end_code  = end_code;
    stat_o.tok_code  = (tok_q.token_kind < TOK_NUM) ? ERR_BADOP : ERR_OTHER;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

@@ src/lree_ctrl.sv @@
// Controller: sequences each token through action lookup, reductions and result flush.
`timescale 1ns / 1ps
`default_nettype none
module lree_ctrl import lree_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);
  ctrl_state_e state_q, state_d;
  logic [2:0]  code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ERR_OTHER;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_CHECK;
      S_CHECK: begin
        if (stat_i.disc) begin
          state_d = S_IDLE;
        end else if (stat_i.tok_bad) begin
          code_d  = ERR_LEX;
          state_d = S_FAIL;
        end else if (stat_i.tok_end && stat_i.top_zero) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        case (stat_i.act)
          ACT_SHIFT: begin
            if (stat_i.full) begin
              code_d  = ERR_OTHER;
              state_d = S_FAIL;
            end else begin
              state_d = S_FLUSH;
            end
          end
          ACT_ACC: if (stat_i.emit_ok) state_d = S_FLUSH;
          ACT_RED: begin
            if (stat_i.short_stk) begin
              code_d  = ERR_OTHER;
              state_d = S_FAIL;
            end else begin
              state_d = S_RED;
            end
          end
          default: begin
            if (stat_i.tok_end) begin
              state_d = S_ERRK;
            end else begin
              code_d  = stat_i.tok_code;
              state_d = S_FAIL;
            end
          end
        endcase
      end
      S_ERRK: begin
        code_d  = stat_i.end_code;
        state_d = S_FAIL;
      end
      S_FAIL: if (stat_i.emit_ok) state_d = S_FLUSH;
      S_RED: begin
        if (stat_i.goto_bad) begin
          code_d  = ERR_OTHER;
          state_d = S_FAIL;
        end else if (stat_i.rcls == RC_MUL) begin
          state_d = S_MUL;
        end else if (stat_i.rcls == RC_DIV) begin
          state_d = S_DIVGO;
        end else begin
          state_d = S_WB;
        end
      end
      S_MUL:   state_d = S_WB;
      S_DIVGO: state_d = S_DIVW;
      S_DIVW:  if (stat_i.div_done) state_d = S_WB;
      S_WB:    if (!stat_i.wb_emit || stat_i.emit_ok) state_d = S_ACT;
      S_FLUSH: if (!stat_i.pend_v || stat_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op   = C_NONE;
    cmd_o.code = code_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = C_LOAD;
      end
      S_CHECK: if (stat_i.disc) cmd_o.op = C_DISC;
      S_ACT: begin
        if ((stat_i.act == ACT_SHIFT) && !stat_i.full) cmd_o.op = C_SHIFT;
        else if ((stat_i.act == ACT_ACC) && stat_i.emit_ok) cmd_o.op = C_ACC;
      end
      S_FAIL:  if (stat_i.emit_ok) cmd_o.op = C_FAIL;
      S_RED:   if (!stat_i.goto_bad) cmd_o.op = C_CALC;
      S_MUL:   cmd_o.op = C_MULFIN;
      S_DIVGO: cmd_o.op = C_DIVGO;
      S_DIVW:  if (stat_i.div_done) cmd_o.op = C_DIVFIN;
      S_WB:    if (!stat_i.wb_emit || stat_i.emit_ok) cmd_o.op = C_WB;
      S_FLUSH: if (stat_i.pend_v && stat_i.out_free) cmd_o.op = C_FLUSH;
      default: cmd_o.op = C_NONE;
    endcase
  end
endmodule
`default_nettype wire
